FILE: rtl/preemptive_priority_scheduler_assert.svh
// Assertion macros used by the checker file.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH

// Same-cycle implication, off while reset is applied.
`define PPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Next-cycle implication, off while reset is applied.
`define PPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

FILE: rtl/ppsch_pkg.sv
package ppsch_pkg;

    // Fixed field widths
    localparam int SLOT_W = 4;
    localparam int PRIO_W = 8;
    localparam int TIME_W = 16;
    localparam int CFG_W  = 5;

    // Operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic              op;
        logic [SLOT_W-1:0] slot;
        logic [PRIO_W-1:0] priority_req;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
    } in_beat_t;

    typedef struct packed {
        logic              idle;
        logic [SLOT_W-1:0] ran_slot;
        logic              finished;
        logic [TIME_W-1:0] finish_time;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
    } out_beat_t;

    // One task slot as stored in the table RAM
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] remaining;
    } task_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_TURN,
        ST_WAIT,
        ST_RESULT
    } state_t;

endpackage

FILE: rtl/ppsch_ram.sv
module ppsch_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/preemptive_priority_scheduler.sv
// Channel | Direction | Handshake          | Beat
// in      | input     | in_valid/in_stall  | ppsch_pkg::in_beat_t (load or tick)
// out     | output    | out_valid/out_stall| ppsch_pkg::out_beat_t (one per tick)
// cfg     | input     | cfg_we             | task_count, 5 bits
//
// A load beat is written to its slot in the table RAM on accept.
// A tick scans the table, advances time, runs the picked slot, gives a result;
// the scan reads one table entry per cycle through the RAM read port into one
// shared compare unit; one subtractor forms turnaround and waiting on finish.
// rst_n clears time, task_count and the per-slot valid bits; RAM needs no clear.
// A stalled result holds in the output register; the next item is still taken.
module preemptive_priority_scheduler #(
    parameter int TASK_SLOTS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  ppsch_pkg::in_beat_t              in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output ppsch_pkg::out_beat_t             out_data,
    input  logic                             cfg_we,
    input  logic [ppsch_pkg::CFG_W-1:0]      cfg_data
);

    import ppsch_pkg::*;

    localparam int AW    = $clog2(TASK_SLOTS);
    localparam int CNT_W = $clog2(TASK_SLOTS + 1);
    localparam int ENT_W = $bits(task_entry_t);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]      count_reg;
    logic [TIME_W-1:0]     time_reg, time_next;
    logic [TASK_SLOTS-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]      issue_reg, issue_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         pend_idx_reg, pend_idx_next;
    logic                  found_reg, found_next;
    logic [AW-1:0]         best_idx_reg, best_idx_next;
    task_entry_t           best_reg, best_next;
    logic                  done_reg, done_next;
    logic [TIME_W-1:0]     turn_reg, turn_next;
    logic [TIME_W-1:0]     wait_reg, wait_next;
    logic                  out_valid_reg, out_valid_next;
    out_beat_t             out_data_reg, out_data_next;

    logic                  in_accept;
    logic                  out_free;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    task_entry_t           ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [ENT_W-1:0]      ram_rdata;
    task_entry_t           cand;
    logic                  cand_live;
    logic                  cand_better;
    logic [TIME_W-1:0]     sub_a, sub_b, sub_res;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Task table
    ppsch_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TASK_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared compare unit: entry read back against the best so far
    assign cand      = task_entry_t'(ram_rdata);
    assign cand_live = valid_reg[pend_idx_reg] && (cand.remaining != '0)
                       && (cand.arrival <= time_reg);
    assign cand_better = !found_reg || (cand.prio > best_reg.prio)
                         || ((cand.prio == best_reg.prio)
                             && (cand.arrival < best_reg.arrival));

    // Shared saturating subtractor
    assign sub_a   = (state_reg == ST_TURN) ? time_reg : turn_reg;
    assign sub_b   = (state_reg == ST_TURN) ? best_reg.arrival : best_reg.burst;
    assign sub_res = (sub_a > sub_b) ? (sub_a - sub_b) : '0;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (in_data.op == OP_TICK))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue_reg == count_reg)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (found_reg && (best_reg.remaining == TIME_W'(1)))
                begin
                    state_next = ST_TURN;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_TURN:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and RAM control
    always_comb
    begin
        time_next      = time_reg;
        valid_next     = valid_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_next      = best_reg;
        done_next      = done_reg;
        turn_next      = turn_reg;
        wait_next      = wait_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = AW'(in_data.slot);
        ram_wdata      = '{prio: in_data.priority_req, arrival: in_data.arrival,
                           burst: in_data.burst, remaining: in_data.burst};
        ram_raddr      = issue_reg[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_data.op == OP_LOAD)
                    begin
                        // Load beat: write the slot, mark it valid
                        if (int'(in_data.slot) < TASK_SLOTS)
                        begin
                            ram_we                = 1'b1;
                            valid_next[ram_waddr] = 1'b1;
                        end
                    end
                    else
                    begin
                        issue_next = '0;
                        found_next = 1'b0;
                    end
                end
            end
            ST_SCAN:
            begin
                // Issue one read per cycle, compare the one returned
                if (issue_reg != count_reg)
                begin
                    issue_next    = issue_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[AW-1:0];
                end
                if (pend_reg && cand_live && cand_better)
                begin
                    found_next    = 1'b1;
                    best_idx_next = pend_idx_reg;
                    best_next     = cand;
                end
            end
            ST_UPDATE:
            begin
                // Advance time, run the picked slot one unit
                time_next = (time_reg == '1) ? time_reg : time_reg + 1'b1;
                done_next = found_reg && (best_reg.remaining == TIME_W'(1));
                turn_next = '0;
                wait_next = '0;
                if (found_reg)
                begin
                    ram_we              = 1'b1;
                    ram_waddr           = best_idx_reg;
                    ram_wdata           = best_reg;
                    ram_wdata.remaining = best_reg.remaining - 1'b1;
                end
            end
            ST_TURN:
            begin
                turn_next = sub_res;
            end
            ST_WAIT:
            begin
                wait_next = sub_res;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.idle        = !found_reg;
                    out_data_next.ran_slot    = found_reg ? SLOT_W'(best_idx_reg) : '0;
                    out_data_next.finished    = done_reg;
                    out_data_next.finish_time = time_reg;
                    out_data_next.turnaround  = turn_reg;
                    out_data_next.waiting     = wait_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            time_reg      <= '0;
            valid_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            time_reg      <= time_next;
            valid_reg     <= valid_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            // task_count saturates at the table depth
            if (cfg_we)
            begin
                count_reg <= (int'(cfg_data) > TASK_SLOTS) ? CNT_W'(TASK_SLOTS)
                                                            : CNT_W'(cfg_data);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        issue_reg    <= issue_next;
        pend_idx_reg <= pend_idx_next;
        found_reg    <= found_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        done_reg     <= done_next;
        turn_reg     <= turn_next;
        wait_reg     <= wait_next;
        out_data_reg <= out_data_next;
    end

endmodule

FILE: rtl/ppsch_checker.sv
`include "preemptive_priority_scheduler_assert.svh"

module ppsch_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input ppsch_pkg::in_beat_t         in_data,
    input logic                        out_valid,
    input logic                        out_stall,
    input ppsch_pkg::out_beat_t        out_data,
    input logic                        cfg_we,
    input logic [ppsch_pkg::CFG_W-1:0] cfg_data
);

    import ppsch_pkg::*;

    // Stalled result beat holds
    `PPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

    // A tick beat keeps the input stalled while it is worked
    `PPS_ASSERT_NEXT(a_tick_busy, clk, rst_n, in_valid && !in_stall && (in_data.op == OP_TICK), in_stall)

    // Idle tick reports nothing else
    `PPS_ASSERT_NOW(a_idle_clean, clk, rst_n, out_valid && out_data.idle, (out_data.ran_slot == '0) && !out_data.finished && (out_data.turnaround == '0) && (out_data.waiting == '0))

    // Finish comes from a running slot, waiting never above turnaround
    `PPS_ASSERT_NOW(a_finish_sane, clk, rst_n, out_valid && out_data.finished, !out_data.idle && (out_data.waiting <= out_data.turnaround))

endmodule

bind preemptive_priority_scheduler ppsch_checker u_checker (.*);
